// File: sv/hdlc_frame_builder_macros.svh
// Assertion helpers used by the datapath module.
`ifndef HDLC_FRAME_BUILDER_MACROS_SVH
`define HDLC_FRAME_BUILDER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HFB_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define HFB_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define HFB_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: sv/hfb_pkg.sv
package hfb_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [2:0]  STUFF_RUN = 3'd5;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam int          CNT_W     = 5;
   localparam logic [CNT_W-1:0] BYTE_BITS = 5'd8;
   localparam logic [CNT_W-1:0] FCS_BITS  = 5'd16;

   typedef struct packed {
      logic load_byte;
      logic start_flag;
      logic load_fcs;
      logic load_eflag;
      logic line_bit;
      logic stuff_zero;
      logic stuff_en;
      logic crc_en;
      logic pad;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic stuff_due;
      logic byte_wrap;
      logic pcnt_zero;
      logic pend_valid;
      logic push_ok;
      logic in_frame;
      logic end_flag;
   } status_type;

endpackage

// File: sv/hdlc_frame_builder.sv
// HDLC frame builder: one line bit per cycle through a stuffing shifter, unless an output stall holds it.
// Steps: a request is accepted, a start flag is queued if no frame is open, the payload
// byte is shifted out with any stuffed zeros, and the request closes with a flush; a
// frame-ending request also sends the FCS with stuffed zeros, an end flag and a pad step.
// A new request is taken only once the previous one has flushed.
// Reset (synchronous, active high) clears the CRC to all ones and awaits a start flag.
module hdlc_frame_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] line_byte, [23:8] frame_bits
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] frame_done
);
   import hfb_pkg::*;

   cmd_type    cmd;
   status_type status;

   hfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hfb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_payload (req_tdata),
      .in_end     (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: sv/hfb_ctrl.sv
module hfb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hfb_pkg::status_type status,
   output hfb_pkg::cmd_type   cmd
);
   import hfb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FLAG  = 3'd1;
   localparam logic [2:0] S_DATA  = 3'd2;
   localparam logic [2:0] S_FCS   = 3'd3;
   localparam logic [2:0] S_EFLAG = 3'd4;
   localparam logic [2:0] S_PAD   = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type          cmd_raw;
   logic             stall;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd_raw  = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff) inside
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_raw.load_byte = 1'b1;
               cnt_in            = BYTE_BITS;
               state_in          = status.in_frame ? S_DATA : S_FLAG;
            end
         end
         S_FLAG: begin
            cmd_raw.start_flag = 1'b1;
            state_in           = S_DATA;
         end
         S_DATA, S_FCS: begin
            if (status.stuff_due) begin
               // insert the zero after a run of ones
               cmd_raw.line_bit   = 1'b1;
               cmd_raw.stuff_zero = 1'b1;
            end else if (cnt_ff != '0) begin
               cmd_raw.line_bit = 1'b1;
               cmd_raw.stuff_en = 1'b1;
               cmd_raw.crc_en   = (state_ff == S_DATA);
               cnt_in           = cnt_ff - 1'b1;
            end else if (state_ff == S_DATA) begin
               if (status.end_flag) begin
                  cmd_raw.load_fcs = 1'b1;
                  cnt_in           = FCS_BITS;
                  state_in         = S_FCS;
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               cmd_raw.load_eflag = 1'b1;
               cnt_in             = BYTE_BITS;
               state_in           = S_EFLAG;
            end
         end
         S_EFLAG: begin
            if (cnt_ff != '0) begin
               cmd_raw.line_bit = 1'b1;
               cnt_in           = cnt_ff - 1'b1;
            end else begin
               state_in = S_PAD;
            end
         end
         S_PAD: begin
            cmd_raw.pad = 1'b1;
            state_in    = S_FLUSH;
         end
         S_FLUSH: begin
            cmd_raw.flush = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold while a finished byte has nowhere to go
      stall = (cmd_raw.line_bit && status.byte_wrap && status.pend_valid && !status.push_ok)
            || (cmd_raw.pad && !status.pcnt_zero && status.pend_valid && !status.push_ok)
            || (cmd_raw.flush && !status.push_ok);

      cmd = cmd_raw;
      if (stall) begin
         cmd      = '0;
         state_in = state_ff;
         cnt_in   = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: sv/hfb_datapath.sv
`include "hdlc_frame_builder_macros.svh"

module hfb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  hfb_pkg::cmd_type    cmd,
   output hfb_pkg::status_type status,
   input  logic [7:0]          in_payload,
   input  logic                in_end,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);
   import hfb_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  ones_ff, ones_in;
   logic [7:0]  part_ff, part_in;
   logic [2:0]  pcnt_ff, pcnt_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] sreg_ff, sreg_in;
   logic [7:0]  pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        in_frame_ff, in_frame_in;
   logic        end_ff, end_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;
   logic        out_done_ff, out_done_in;
   logic [15:0] out_bits_ff, out_bits_in;

   logic        push, push_last, push_done;
   logic [15:0] push_bits;
   logic        line_val, crc_fb;
   logic [7:0]  byte_val;

   function automatic logic [15:0] sat_add(input logic [15:0] t, input logic [3:0] n);
      logic [16:0] s;
      s = {1'b0, t} + {13'b0, n};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   assign status.stuff_due  = (ones_ff == STUFF_RUN);
   assign status.byte_wrap  = (pcnt_ff == 3'd7);
   assign status.pcnt_zero  = (pcnt_ff == 3'd0);
   assign status.pend_valid = pend_valid_ff;
   assign status.push_ok    = !out_valid_ff || rsp_tready;
   assign status.in_frame   = in_frame_ff;
   assign status.end_flag   = end_ff;

   assign line_val = cmd.stuff_zero ? 1'b0 : sreg_ff[0];
   assign crc_fb   = crc_ff[0] ^ line_val;
   assign byte_val = part_ff | ({7'b0, line_val} << pcnt_ff);

   always_comb begin
      crc_in        = crc_ff;
      ones_in       = ones_ff;
      part_in       = part_ff;
      pcnt_in       = pcnt_ff;
      total_in      = total_ff;
      sreg_in       = sreg_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      in_frame_in   = in_frame_ff;
      end_in        = end_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      push_done     = 1'b0;
      push_bits     = '0;

      if (cmd.load_byte) begin
         sreg_in = {8'b0, in_payload};
         end_in  = in_end;
      end
      if (cmd.start_flag) begin
         pend_in       = FLAG_BYTE;
         pend_valid_in = 1'b1;
         total_in      = sat_add(total_ff, 4'd8);
         in_frame_in   = 1'b1;
      end
      if (cmd.load_fcs) begin
         sreg_in = ~crc_ff;
      end
      if (cmd.load_eflag) begin
         sreg_in = {8'b0, FLAG_BYTE};
      end
      if (cmd.line_bit) begin
         if (!cmd.stuff_zero) begin
            sreg_in = sreg_ff >> 1;
         end
         if (cmd.crc_en) begin
            crc_in = (crc_ff >> 1) ^ (crc_fb ? CRC_POLY : 16'h0000);
         end
         if (cmd.stuff_zero) begin
            ones_in = '0;
         end else if (cmd.stuff_en) begin
            ones_in = line_val ? ones_ff + 1'b1 : 3'd0;
         end
         if (pcnt_ff == 3'd7) begin
            push          = pend_valid_ff;
            pend_in       = byte_val;
            pend_valid_in = 1'b1;
            total_in      = sat_add(total_ff, 4'd8);
            part_in       = '0;
            pcnt_in       = '0;
         end else begin
            part_in = byte_val;
            pcnt_in = pcnt_ff + 1'b1;
         end
      end
      if (cmd.pad && (pcnt_ff != 3'd0)) begin
         // fill the tail with the leading bits of a flag
         push          = pend_valid_ff;
         pend_in       = part_ff | (FLAG_BYTE << pcnt_ff);
         pend_valid_in = 1'b1;
         total_in      = sat_add(total_ff, {1'b0, pcnt_ff});
         part_in       = '0;
         pcnt_in       = '0;
      end
      if (cmd.flush) begin
         push          = 1'b1;
         push_last     = 1'b1;
         push_done     = end_ff;
         push_bits     = end_ff ? total_ff : 16'h0000;
         pend_valid_in = 1'b0;
         if (end_ff) begin
            crc_in      = CRC_INIT;
            ones_in     = '0;
            part_in     = '0;
            pcnt_in     = '0;
            total_in    = '0;
            in_frame_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      out_bits_in  = out_bits_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_data_in  = pend_ff;
         out_last_in  = push_last;
         out_done_in  = push_done;
         out_bits_in  = push_bits;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CRC_INIT;
         ones_ff       <= '0;
         part_ff       <= '0;
         pcnt_ff       <= '0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
         in_frame_ff   <= 1'b0;
         end_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         ones_ff       <= ones_in;
         part_ff       <= part_in;
         pcnt_ff       <= pcnt_in;
         total_ff      <= total_in;
         pend_valid_ff <= pend_valid_in;
         in_frame_ff   <= in_frame_in;
         end_ff        <= end_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sreg_ff     <= sreg_in;
      pend_ff     <= pend_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
      out_bits_ff <= out_bits_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_bits_ff, out_data_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   `HFB_ASSERT_ALWAYS(a_ones_bounded, ones_ff <= STUFF_RUN, "ones run passed the stuffing limit")
   `HFB_ASSERT_IMPLY(a_no_overwrite, push && out_valid_ff, rsp_tready, "result overwritten")
   `HFB_ASSERT_NEXT(a_frame_closed, cmd.flush && end_ff, !in_frame_ff && (pcnt_ff == 3'd0), "frame state not cleared")
   `HFB_ASSERT_IMPLY(a_bits_with_done, out_valid_ff && !out_done_ff, out_bits_ff == 16'h0000, "bit count outside frame end")

endmodule

// File: tb/hdlc_frame_builder_checker.sv
`timescale 1ns / 1ps

module hdlc_frame_builder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] payload_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // [7:0] line_byte, [23:8] frame_bits
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,    // [0] frame_done
   output int          mismatch_count,
   output int          bytes_pending
);

   localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
   localparam logic [2:0]  ONES_LIMIT   = 3'd5;
   localparam logic [15:0] FCS_POLY     = 16'h8408;
   localparam logic [15:0] FCS_PRESET   = 16'hFFFF;
   localparam int          MAX_BURST    = 7;

   typedef struct {
      logic [7:0]  line_byte;
      logic        run_last;
      logic        frame_done;
      logic [15:0] frame_bits;
   } line_word_type;

   line_word_type line_bytes_due[$];

   logic [15:0] fcs_acc         = FCS_PRESET;
   logic [2:0]  ones_seen       = '0;
   logic [7:0]  shift_byte      = '0;
   logic [3:0]  shift_count     = '0;
   logic        frame_open      = 1'b0;
   logic [15:0] frame_bit_count = '0;
   logic [7:0]  burst [0:MAX_BURST-1];
   int          burst_len;

   function automatic void clear_frame();
      fcs_acc         = FCS_PRESET;
      ones_seen       = '0;
      shift_byte      = '0;
      shift_count     = '0;
      frame_open      = 1'b0;
      frame_bit_count = '0;
   endfunction

   // Saturate the frame length at the width of the field.
   function automatic void count_bits(int n);
      int sum;
      sum = int'(frame_bit_count) + n;
      frame_bit_count = (sum > 65535) ? 16'hFFFF : 16'(sum);
   endfunction

   function automatic void emit_byte(logic [7:0] value);
      if (burst_len < MAX_BURST) begin
         burst[burst_len] = value;
         burst_len++;
      end
   endfunction

   function automatic void put_line_bit(logic value);
      shift_byte  = shift_byte | (8'(value) << shift_count[2:0]);
      shift_count = shift_count + 4'd1;
      if (shift_count == 4'd8) begin
         emit_byte(shift_byte);
         count_bits(8);
         shift_byte  = '0;
         shift_count = '0;
      end
   endfunction

   // Insert a zero after five ones in a row.
   function automatic void put_stuffed_bit(logic value);
      put_line_bit(value);
      if (value) begin
         ones_seen = ones_seen + 3'd1;
         if (ones_seen >= ONES_LIMIT) begin
            put_line_bit(1'b0);
            ones_seen = '0;
         end
      end else begin
         ones_seen = '0;
      end
   endfunction

   function automatic void predict_line_bytes(logic [7:0] payload, logic frame_end);
      logic [15:0]   crc;
      logic [15:0]   fcs;
      logic [15:0]   closed_bits;
      line_word_type word;
      closed_bits = '0;
      burst_len   = 0;
      if (!frame_open) begin
         emit_byte(FLAG_PATTERN);
         count_bits(8);
         frame_open = 1'b1;
      end
      crc = fcs_acc ^ {8'h00, payload};
      for (int k = 0; k < 8; k++)
         crc = crc[0] ? ((crc >> 1) ^ FCS_POLY) : (crc >> 1);
      fcs_acc = crc;
      for (int k = 0; k < 8; k++)
         put_stuffed_bit(payload[k]);
      if (frame_end) begin
         fcs = ~fcs_acc;
         for (int k = 0; k < 16; k++)
            put_stuffed_bit(fcs[k]);
         for (int k = 0; k < 8; k++)
            put_line_bit(FLAG_PATTERN[k]);
         // Pad a partial byte with the head of another flag.
         if (shift_count != 0) begin
            emit_byte(shift_byte | (FLAG_PATTERN << shift_count[2:0]));
            count_bits(int'(shift_count));
         end
         closed_bits = frame_bit_count;
         clear_frame();
      end
      for (int r = 0; r < burst_len; r++) begin
         word.line_byte  = burst[r];
         word.run_last   = (r == burst_len - 1);
         word.frame_done = word.run_last && frame_end;
         word.frame_bits = word.frame_done ? closed_bits : 16'd0;
         line_bytes_due.push_back(word);
      end
   endfunction

   always @(posedge clock) begin
      line_word_type due;
      if (reset) begin
         clear_frame();
         line_bytes_due.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_line_bytes(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (line_bytes_due.size() == 0) begin
               $error("unexpected line byte %h", rsp_tdata[7:0]);
               mismatch_count++;
            end else begin
               due = line_bytes_due.pop_front();
               if (rsp_tdata[7:0] !== due.line_byte) begin
                  $error("line_byte: expected %h, got %h", due.line_byte, rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tlast !== due.run_last) begin
                  $error("run_last: expected %b, got %b", due.run_last, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tuser !== due.frame_done) begin
                  $error("frame_done: expected %b, got %b", due.frame_done, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[23:8] !== due.frame_bits) begin
                  $error("frame_bits: expected %0d, got %0d", due.frame_bits,
                         rsp_tdata[23:8]);
                  mismatch_count++;
               end
            end
         end
      end
      bytes_pending <= line_bytes_due.size();
   end

endmodule

// File: tb/hdlc_frame_builder_tb.sv
`timescale 1ns / 1ps

module hdlc_frame_builder_tb;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] payload_byte
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] line_byte, [23:8] frame_bits
   logic        rsp_tlast;
   logic        rsp_tuser;          // [0] frame_done

   int          mismatch_count;
   int          bytes_pending;
   logic        send_pace = 1'b1;
   logic        sink_pace = 1'b1;
   int          sent_count = 0;

   always #6 clock = ~clock;

   hdlc_frame_builder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   hdlc_frame_builder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   task automatic send_payload(logic [7:0] payload, logic frame_end);
      int gap;
      gap = send_pace ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tlast  <= frame_end;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Hold off until every predicted line byte has drained.
   task automatic drain_line_bytes();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
   endtask

   // Favor ones runs and flag patterns to exercise the stuffer.
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 7))
         0, 1:    return 8'hFF;
         2:       return 8'h7E;
         3:       return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = sink_pace ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int frame_len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-byte frames: start flag, byte, FCS and end flag at once
      send_payload(8'h00, 1'b1);
      send_payload(8'hFF, 1'b1);
      send_payload(8'h7E, 1'b1);
      // multi-byte frames, with long runs of ones across byte borders
      send_payload(8'hFF, 1'b0);
      send_payload(8'hFF, 1'b0);
      send_payload(8'hFF, 1'b1);
      send_payload(8'h00, 1'b0);
      send_payload(8'h01, 1'b0);
      send_payload(8'h80, 1'b0);
      send_payload(8'h3E, 1'b1);
      send_payload(8'hF8, 1'b0);
      send_payload(8'h1F, 1'b0);
      send_payload(8'h55, 1'b0);
      send_payload(8'hAA, 1'b1);
      send_payload(8'h12, 1'b0);
      send_payload(8'h34, 1'b1);
      drain_line_bytes();

      while (sent_count < 320) begin
         frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
                                                 : $urandom_range(1, 8);
         send_pace = ($urandom_range(0, 3) != 0);
         sink_pace = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < frame_len; i++)
            send_payload(pick_payload(), i == frame_len - 1);
      end
      drain_line_bytes();

      send_pace = 1'b1;
      sink_pace = 1'b1;
      send_payload(8'hA5, 1'b1);
      send_payload(8'h5A, 1'b0);
      send_payload(8'hC3, 1'b1);

      drain_line_bytes();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
